FILE: src/array_linked_circular_deque_defines.svh
// Assertion macros used by the bound checker, ald_checker.
`ifndef ARRAY_LINKED_CIRCULAR_DEQUE_DEFINES_SVH
`define ARRAY_LINKED_CIRCULAR_DEQUE_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define ALD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ALD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ald_pkg.sv
package ald_pkg;

  // operation codes carried in in_kind
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LINK2,
    ST_POP_RD,
    ST_POP_FIN,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_DONE
  } state_t;

  // commands to the slot allocator
  typedef struct packed {
    logic start;
    logic scan;
    logic set;
    logic clr;
  } alloc_cmd_t;

endpackage

FILE: src/ald_ram.sv
module ald_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ald_alloc.sv
// Slot occupancy flags and lowest-free search, one slot per cycle.
module ald_alloc
  import ald_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  alloc_cmd_t               cmd,
  input  logic [$clog2(SLOTS)-1:0] clr_idx,
  output logic                     hit,
  output logic [$clog2(SLOTS)-1:0] idx
);

  localparam int IW = $clog2(SLOTS);

  logic [SLOTS-1:0] in_use_r;
  logic [SLOTS-1:0] in_use_nxt;
  logic [IW-1:0]    ptr_r;
  logic [IW-1:0]    ptr_nxt;

  assign hit = !in_use_r[ptr_r];
  assign idx = ptr_r;

  always_comb begin
    in_use_nxt = in_use_r;
    if (cmd.set) begin
      in_use_nxt[ptr_r] = 1'b1;
    end
    if (cmd.clr) begin
      in_use_nxt[clr_idx] = 1'b0;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.start) begin
      ptr_nxt = '0;
    end else if (cmd.scan && !hit) begin
      ptr_nxt = ptr_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      ptr_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

endmodule

FILE: src/array_linked_circular_deque.sv
// Deque held as a circular singly linked list in a table of SLOTS slots.
// Input channel: in_valid/in_ready with in_kind (push front, push back,
// pop front, pop back) and in_push_value. Every accepted word yields exactly
// one result word on out_valid/out_ready: out_pop_value, out_status and
// out_occupancy (entries held afterwards, low 5 bits).
// One operation is in flight at a time; in_ready is high only when idle.
// Refused pushes (full) and pops (empty) go straight to the result. A push
// searches for the lowest free slot, one slot per cycle, then links it in;
// pop front, or pop of the last entry, reads the entry and its link; pop back
// walks the links from the head to the tail's predecessor, one link memory
// read per step. The next word can be taken in the cycle after the result
// is handed to the output register.
// Values and links live in two synchronous RAMs with registered reads;
// accesses are ordered by the sequencer, so no read overlaps a pending write.
// Reset (rst_n low, synchronous) clears the slot flags, head, tail, count and
// the output valid flag; RAM contents and the output payload are left as they are.
// A stalled receiver holds the result in the output register; a finished
// operation then waits in its last state and no new word is accepted.
module array_linked_circular_deque
  import ald_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pop_value,
  output logic [1:0]  out_status,
  output logic [4:0]  out_occupancy
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state_r, state_nxt;

  logic [IW-1:0]         head_r, head_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IW-1:0]         vic_r, vic_nxt;     // slot being popped
  logic [IW-1:0]         cur_r, cur_nxt;     // walk position
  logic [IW-1:0]         steps_r, steps_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;
  logic [1:0]            res_status_r, res_status_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_pop_value_r, out_pop_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [4:0]  out_occupancy_r, out_occupancy_nxt;

  // memory ports
  logic                  v_we;
  logic [IW-1:0]         v_waddr;
  logic [VALUE_BITS-1:0] v_wdata;
  logic [VALUE_BITS-1:0] v_rdata;
  logic                  l_we;
  logic [IW-1:0]         l_waddr;
  logic [IW-1:0]         l_wdata;
  logic [IW-1:0]         l_raddr;
  logic [IW-1:0]         l_rdata;

  alloc_cmd_t    acmd;
  logic          a_hit;
  logic [IW-1:0] a_idx;

  logic          accept;
  logic          push_in;
  logic          is_full;
  logic          is_zero;
  logic          is_one;
  logic          front_r;
  logic          walk_hit;
  logic          walk_end;
  logic [IW-1:0] pred;
  logic          out_free;

  assign accept   = in_valid && in_ready;
  assign push_in  = in_kind inside {KIND_PUSH_FRONT, KIND_PUSH_BACK};
  assign is_full  = (count_r == CW'(SLOTS));
  assign is_zero  = (count_r == '0);
  assign is_one   = (count_r == CW'(1));
  assign front_r  = (kind_r == KIND_PUSH_FRONT) || (kind_r == KIND_POP_FRONT);
  assign walk_hit = (l_rdata == vic_r);
  assign walk_end = walk_hit || (steps_r == IW'(SLOTS - 1));
  // a broken ring falls back to the head as predecessor
  assign pred     = walk_hit ? cur_r : head_r;
  assign out_free = !out_valid_r || out_ready;

  ald_ram #(.DEPTH(SLOTS), .WIDTH(VALUE_BITS)) u_value_ram (
    .clk     (clk),
    .wr_en   (v_we),
    .wr_addr (v_waddr),
    .wr_data (v_wdata),
    .rd_addr (vic_r),
    .rd_data (v_rdata)
  );

  ald_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_link_ram (
    .clk     (clk),
    .wr_en   (l_we),
    .wr_addr (l_waddr),
    .wr_data (l_wdata),
    .rd_addr (l_raddr),
    .rd_data (l_rdata)
  );

  ald_alloc #(.SLOTS(SLOTS)) u_alloc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (acmd),
    .clr_idx (vic_r),
    .hit     (a_hit),
    .idx     (a_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (push_in) begin
            state_nxt = is_full ? ST_DONE : ST_SCAN;
          end else if (is_zero) begin
            state_nxt = ST_DONE;
          end else if (in_kind == KIND_POP_FRONT || is_one) begin
            state_nxt = ST_POP_RD;
          end else begin
            state_nxt = ST_WALK_RD;
          end
        end
      end
      ST_SCAN: begin
        if (a_hit) begin
          state_nxt = is_zero ? ST_DONE : ST_LINK2;
        end
      end
      ST_LINK2:    state_nxt = ST_DONE;
      ST_POP_RD:   state_nxt = ST_POP_FIN;
      ST_POP_FIN:  state_nxt = ST_DONE;
      ST_WALK_RD:  state_nxt = ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake, allocator and memory controls
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    acmd.start = accept;
    acmd.scan  = (state_r == ST_SCAN);
    acmd.set   = (state_r == ST_SCAN) && a_hit;
    acmd.clr   = (state_r == ST_POP_FIN) || ((state_r == ST_WALK_CMP) && walk_end);
    v_we       = (state_r == ST_SCAN) && a_hit;
    v_waddr    = a_idx;
    v_wdata    = val_r;
    l_we       = 1'b0;
    l_waddr    = tail_r;
    l_wdata    = head_r;
    l_raddr    = vic_r;
    unique case (state_r)
      ST_SCAN: begin
        if (a_hit) begin
          l_we = 1'b1;
          if (is_zero) begin
            l_waddr = a_idx;          // lone entry links to itself
            l_wdata = a_idx;
          end else if (front_r) begin
            l_waddr = a_idx;
            l_wdata = head_r;
          end else begin
            l_waddr = tail_r;
            l_wdata = a_idx;
          end
        end
      end
      ST_LINK2: begin
        // close the ring: tail -> head, after either push
        l_we = 1'b1;
      end
      ST_POP_FIN: begin
        if (front_r && !is_one) begin
          l_we    = 1'b1;
          l_wdata = l_rdata;
        end
      end
      ST_WALK_RD: l_raddr = cur_r;
      ST_WALK_CMP: begin
        l_raddr = l_rdata;            // next link fetched while comparing
        if (walk_end) begin
          l_we    = 1'b1;
          l_waddr = pred;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    kind_nxt          = kind_r;
    val_nxt           = val_r;
    vic_nxt           = vic_r;
    cur_nxt           = cur_r;
    steps_nxt         = steps_r;
    res_val_nxt       = res_val_r;
    res_status_nxt    = res_status_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_pop_value_nxt = out_pop_value_r;
    out_status_nxt    = out_status_r;
    out_occupancy_nxt = out_occupancy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt    = in_kind;
          val_nxt     = VALUE_BITS'(in_push_value);
          vic_nxt     = (in_kind == KIND_POP_FRONT) ? head_r : tail_r;
          cur_nxt     = head_r;
          steps_nxt   = '0;
          res_val_nxt = '0;
          if (push_in) begin
            res_status_nxt = is_full ? STAT_FULL : STAT_DONE;
          end else begin
            res_status_nxt = is_zero ? STAT_EMPTY : STAT_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (a_hit) begin
          count_nxt = count_r + CW'(1);
          if (is_zero) begin
            head_nxt = a_idx;
            tail_nxt = a_idx;
          end else if (front_r) begin
            head_nxt = a_idx;
          end else begin
            tail_nxt = a_idx;
          end
        end
      end
      ST_POP_FIN: begin
        res_val_nxt = v_rdata;
        count_nxt   = count_r - CW'(1);
        if (front_r && !is_one) begin
          head_nxt = l_rdata;
        end
      end
      ST_WALK_CMP: begin
        if (walk_end) begin
          tail_nxt    = pred;
          res_val_nxt = v_rdata;
          count_nxt   = count_r - CW'(1);
        end else begin
          cur_nxt   = l_rdata;
          steps_nxt = steps_r + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_pop_value_nxt = 32'(res_val_r);
          out_status_nxt    = res_status_r;
          out_occupancy_nxt = 5'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    val_r           <= val_nxt;
    vic_r           <= vic_nxt;
    cur_r           <= cur_nxt;
    steps_r         <= steps_nxt;
    res_val_r       <= res_val_nxt;
    res_status_r    <= res_status_nxt;
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
    out_occupancy_r <= out_occupancy_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

FILE: src/ald_checker.sv
`include "array_linked_circular_deque_defines.svh"

module ald_checker
  import ald_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pop_value,
  input logic [1:0]  out_status,
  input logic [4:0]  out_occupancy
);

  `ALD_ASSERT(refused_gives_zero, out_valid && out_status != STAT_DONE |-> out_pop_value == 32'd0, "refused word carries a value")
  `ALD_ASSERT(full_at_capacity, out_valid && out_status == STAT_FULL |-> out_occupancy == 5'(SLOTS), "full reported below capacity")
  `ALD_ASSERT(empty_at_zero, out_valid && out_status == STAT_EMPTY |-> out_occupancy == 5'd0, "empty reported with entries held")
  `ALD_ASSERT(out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pop_value) && $stable(out_status), "stalled result word changed")
  `ALD_ASSERT_RST(reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind array_linked_circular_deque ald_checker #(.SLOTS(SLOTS)) u_ald_checker (.*);

FILE: bench/deque_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the deque, keeps its own copy of the slot table
// and compares every result word with the oldest predicted one.
module deque_checker
  import ald_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_push_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_pop_value,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_occupancy,
  output int          fail_count,
  output int          words_awaited
);

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [31:0] pop_value;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } deque_word_t;

  logic [31:0] slot_value [SLOTS];
  logic [3:0]  slot_link  [SLOTS];
  logic        slot_used  [SLOTS];
  logic [3:0]  head;
  logic [3:0]  tail;
  logic [4:0]  count;

  deque_word_t awaited[$];
  deque_word_t want;

  // One operation on the shadow ring; returns the word it should produce.
  function automatic deque_word_t deque_step(input logic [1:0] kind,
                                             input logic [31:0] value);
    deque_word_t res;
    int          free_slot;
    int          i;
    logic [3:0]  slot;
    logic [3:0]  cur;
    logic [3:0]  pred;
    logic        found;
    res = '0;
    res.status = STAT_DONE;
    free_slot = -1;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
      for (i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_used[i]) free_slot = i;
      end
      if (free_slot < 0) begin
        res.status = STAT_FULL;
      end else begin
        slot = 4'(free_slot);
        slot_value[slot] = value;
        slot_used[slot] = 1'b1;
        if (count == 0) begin
          head = slot;
          tail = slot;
          slot_link[slot] = slot;
        end else if (kind == KIND_PUSH_FRONT) begin
          slot_link[slot] = head;
          head = slot;
          slot_link[tail] = head;
        end else begin
          slot_link[tail] = slot;
          tail = slot;
          slot_link[slot] = head;
        end
        count++;
      end
    end else if (count == 0) begin
      res.status = STAT_EMPTY;
    end else if (kind == KIND_POP_FRONT) begin
      res.pop_value = slot_value[head];
      slot_used[head] = 1'b0;
      if (count > 1) begin
        head = slot_link[head];
        slot_link[tail] = head;
      end
      count--;
    end else begin
      res.pop_value = slot_value[tail];
      slot_used[tail] = 1'b0;
      if (count > 1) begin
        // walk from the head to the tail's predecessor; head if the ring is broken
        cur = head;
        pred = head;
        found = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!found) begin
            if (slot_link[cur] == tail) begin
              pred = cur;
              found = 1'b1;
            end else begin
              cur = slot_link[cur];
            end
          end
        end
        tail = pred;
        slot_link[pred] = head;
      end
      count--;
    end
    res.occupancy = count;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_value[i] = '0;
        slot_link[i] = '0;
        slot_used[i] = 1'b0;
      end
      head = '0;
      tail = '0;
      count = '0;
      awaited.delete();
      fail_count = 0;
      words_awaited <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result word with none awaited: pop_value %h status %0d occupancy %0d",
                 out_pop_value, out_status, out_occupancy);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_pop_value !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, out_pop_value);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) awaited.push_back(deque_step(in_kind, in_push_value));
      words_awaited <= awaited.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

// Top of the deque bench: makes the stimulus, drives the result channel's
// ready and gives the verdict. Result words are checked by deque_checker.
module testbench;
  import ald_pkg::*;

  localparam int RANDOM_WORDS = 1650;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [31:0] in_push_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pop_value;
  logic [1:0]  out_status;
  logic [4:0]  out_occupancy;

  int fail_count;
  int words_awaited;
  int words_sent;

  array_linked_circular_deque DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  deque_checker monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .fail_count    (fail_count),
    .words_awaited (words_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. Slowest honest run: ~1700 words, each with the sender's longest
  // idle gap, the block's longest operation and the longest receiver stall,
  // plus two long holds - about 2 ms. Four times that is the ceiling.
  initial begin
    #8000000;
    $display("array_linked_circular_deque verification failed");
    $finish;
  end

  // Offer one word, hold it until taken, then maybe leave a gap.
  // Valid is only dropped when a gap follows, so it never toggles within a step.
  task automatic offer_word(input logic [1:0] kind, input logic [31:0] value);
    int pick;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    pick = $urandom_range(0, 99);
    if (pick >= 55) begin
      in_valid <= 1'b0;
      if (pick < 96) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(15, 40)) @(posedge clk);
    end
  endtask

  // Mostly plain random values, with a share of all-zero, all-one and
  // single-bit patterns so each bit is seen both ways and at the edges.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Receiver: ready in bursts, short stalls, the odd long one. Twice in the
  // run it holds ready low while the sender keeps offering, so the
  // finished operation parks and in_ready stays low behind it.
  initial begin
    int pick;
    bit first_hold_done;
    bit second_hold_done;
    first_hold_done = 1'b0;
    second_hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ((!first_hold_done && words_sent >= 200) ||
          (!second_hold_done && words_sent >= 900)) begin
        if (!first_hold_done) first_hold_done = 1'b1;
        else second_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (pick < 96) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    int done;
    int run;
    int push_pct;
    logic [1:0] kind;
    in_valid      <= 1'b0;
    in_kind       <= KIND_PUSH_FRONT;
    in_push_value <= '0;
    rst_n         <= 1'b0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // pops refused on the empty list, either end
    offer_word(KIND_POP_FRONT, 32'hDEAD_BEEF);
    offer_word(KIND_POP_BACK, 32'h1234_5678);
    // first push links to itself; extremes of the value field
    offer_word(KIND_PUSH_FRONT, 32'h0000_0000);
    offer_word(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    offer_word(KIND_POP_BACK, '0);
    // last entry out through the front, then through the back
    offer_word(KIND_POP_FRONT, '0);
    offer_word(KIND_PUSH_BACK, 32'hA5A5_5A5A);
    offer_word(KIND_POP_BACK, '0);
    // fill all sixteen slots from both ends, then push into a full table
    for (int i = 0; i < 16; i++) begin
      offer_word(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, 32'h0101_0101 * (i + 1));
    end
    offer_word(KIND_PUSH_FRONT, 32'hCAFE_F00D);
    offer_word(KIND_PUSH_BACK, 32'hFFFF_FFFF);

    // Random phases with a push bias of low, even or high, so the ring
    // swings between empty and full and the back-pop walk gets long chains.
    done = 0;
    while (done < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      run = $urandom_range(20, 60);
      repeat (run) begin
        if ($urandom_range(0, 99) < push_pct)
          kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else
          kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        offer_word(kind, pick_value());
        done++;
      end
    end
    in_valid <= 1'b0;

    // drain the awaited result words, then idle before judging
    @(posedge clk);
    while (words_awaited != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("array_linked_circular_deque verification clean");
    end else begin
      $display("array_linked_circular_deque verification failed");
    end
    $finish;
  end

endmodule
